// ----- design/alignment_length_histogram_unit_macros.svh -----
// assertion macros shared by the histogram unit files
`ifndef ALIGNMENT_LENGTH_HISTOGRAM_UNIT_MACROS_SVH
`define ALIGNMENT_LENGTH_HISTOGRAM_UNIT_MACROS_SVH

// clocked assertion, quiet while reset is applied
`define ALH_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);

// clocked assertion that a condition never occurs
`define ALH_ASSERT_NEVER(lbl, clk, rstn, prop, msg) \
  `ALH_ASSERT(lbl, clk, rstn, !(prop), msg)

`endif

// ----- design/alh_pkg.sv -----
// shared types and constants of the alignment length histogram unit
`timescale 1ns / 1ps
`default_nettype none

package alh_pkg;

  // default histogram depth
  localparam int BIN_COUNT_DEFAULT = 256;

  // field widths
  localparam int LEN_W   = 16;
  localparam int CODE_W  = 4;
  localparam int COUNT_W = 32;
  localparam int FLAG_W  = 16;
  localparam int QUAL_W  = 8;

  // queue depths
  localparam int MID_DEPTH = 2;
  localparam int OUT_DEPTH = 4;

  // cigar operation codes of interest
  localparam logic [CODE_W-1:0] OP_SOFT = 4'd4;
  localparam logic [CODE_W-1:0] OP_HARD = 4'd5;

  // register reset values
  localparam logic [FLAG_W-1:0] FORBIDDEN_RESET = 16'h0804;

  // register indexes
  localparam logic [1:0] REG_MIN_QUALITY     = 2'd0;
  localparam logic [1:0] REG_REQUIRED_FLAGS  = 2'd1;
  localparam logic [1:0] REG_FORBIDDEN_FLAGS = 2'd2;

  // operation codes
  localparam logic OPER_RECORD  = 1'b0;
  localparam logic OPER_READOUT = 1'b1;

  // result status
  typedef enum logic [1:0] {
    ST_COUNTED  = 2'd0,
    ST_FILTERED = 2'd1,
    ST_RANGE    = 2'd2,
    ST_READOUT  = 2'd3
  } status_e;

  // input word
  typedef struct packed {
    logic              operation;
    logic [QUAL_W-1:0] mapping_quality;
    logic [FLAG_W-1:0] record_flags;
    logic [LEN_W-1:0]  length_or_bin;
    logic [CODE_W-1:0] head_code;
    logic [LEN_W-1:0]  head_count;
    logic [CODE_W-1:0] second_code;
    logic [LEN_W-1:0]  second_count;
    logic [CODE_W-1:0] tail_code;
    logic [LEN_W-1:0]  tail_count;
    logic [CODE_W-1:0] before_tail_code;
    logic [LEN_W-1:0]  before_tail_count;
  } in_word_t;

  // result word
  typedef struct packed {
    status_e            status;
    logic [COUNT_W-1:0] read_length_count;
    logic [COUNT_W-1:0] aligned_length_count;
  } out_word_t;

  // filter configuration
  typedef struct packed {
    logic [QUAL_W-1:0] min_quality;
    logic [FLAG_W-1:0] required_flags;
    logic [FLAG_W-1:0] forbidden_flags;
  } cfg_t;

  // classified command from front to back
  typedef struct packed {
    status_e          kind;
    logic             bin_ok;
    logic [LEN_W-1:0] rl_bin;
    logic [LEN_W-1:0] al_bin;
  } cmd_t;

endpackage

`default_nettype wire

// ----- design/alh_fifo.sv -----
// small register queue used between the front and back and on the result side
`timescale 1ns / 1ps
`default_nettype none
`include "alignment_length_histogram_unit_macros.svh"

module alh_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire logic [WIDTH-1:0]           data_i,
  input  wire logic                       pop_i,
  output logic      [WIDTH-1:0]           data_o,
  output logic      [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH+1);

  logic [WIDTH-1:0] store_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // pointer step with wrap
  function automatic logic [PTR_W-1:0] step_ptr(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH-1)) r = '0;
    else r = p + PTR_W'(1);
    return r;
  endfunction

  // pointer and fill level update
  always_comb begin
    wr_ptr_d = push_i ? step_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? step_ptr(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + CNT_W'(1);
    else if (!push_i && pop_i) cnt_d = cnt_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // word storage
  always_ff @(posedge clk_i) begin
    if (push_i) store_q[wr_ptr_q] <= data_i;
  end

  assign data_o  = store_q[rd_ptr_q];
  assign count_o = cnt_q;

  // users never overfill or underrun the queue
  `ALH_ASSERT(a_no_overflow, clk_i, rst_ni, (push_i && !pop_i) |-> (cnt_q != CNT_W'(DEPTH)), "queue overflow")
  `ALH_ASSERT(a_no_underrun, clk_i, rst_ni, pop_i |-> (cnt_q != '0), "pop from empty queue")
  `ALH_ASSERT(a_level_tracks, clk_i, rst_ni, (push_i && pop_i) |=> (cnt_q == $past(cnt_q)), "level drift")

endmodule

`default_nettype wire

// ----- design/alh_front.sv -----
// front end: filters and classifies each word and works out its bin indices
`timescale 1ns / 1ps
`default_nettype none

module alh_front #(
  parameter int BIN_COUNT = alh_pkg::BIN_COUNT_DEFAULT
) (
  input  wire alh_pkg::in_word_t word_i,
  input  wire alh_pkg::cfg_t     cfg_i,
  output alh_pkg::cmd_t          cmd_o
);

  localparam int LEN_W = alh_pkg::LEN_W;

  logic             pass;
  logic [LEN_W-1:0] head_clip;
  logic [LEN_W-1:0] tail_clip;
  logic [LEN_W:0]   clip;
  logic [LEN_W:0]   len_ext;
  logic             in_range;
  logic [LEN_W-1:0] aligned;

  // clip length at one end: skip a hard clip, count a soft clip
  function automatic logic [LEN_W-1:0] end_clip(
    input logic [alh_pkg::CODE_W-1:0] code0,
    input logic [LEN_W-1:0]           count0,
    input logic [alh_pkg::CODE_W-1:0] code1,
    input logic [LEN_W-1:0]           count1
  );
    logic [alh_pkg::CODE_W-1:0] code;
    logic [LEN_W-1:0]           count;
    code  = code0;
    count = count0;
    if (code0 == alh_pkg::OP_HARD) begin
      code  = code1;
      count = count1;
    end
    return (code == alh_pkg::OP_SOFT) ? count : '0;
  endfunction

  // filter tests
  assign pass = (word_i.mapping_quality >= cfg_i.min_quality) &&
                ((word_i.record_flags & cfg_i.required_flags) == cfg_i.required_flags) &&
                ((word_i.record_flags & cfg_i.forbidden_flags) == '0);

  // clip lengths from both cigar ends
  assign head_clip = end_clip(word_i.head_code, word_i.head_count,
                              word_i.second_code, word_i.second_count);
  assign tail_clip = end_clip(word_i.tail_code, word_i.tail_count,
                              word_i.before_tail_code, word_i.before_tail_count);
  assign clip      = {1'b0, head_clip} + {1'b0, tail_clip};

  // range checks and aligned length
  assign len_ext  = {1'b0, word_i.length_or_bin};
  assign in_range = len_ext < (LEN_W+1)'(BIN_COUNT);
  assign aligned  = word_i.length_or_bin - clip[LEN_W-1:0];

  // classification
  always_comb begin
    cmd_o.bin_ok = in_range;
    cmd_o.rl_bin = word_i.length_or_bin;
    cmd_o.al_bin = aligned;
    if (word_i.operation == alh_pkg::OPER_READOUT) begin
      cmd_o.kind   = alh_pkg::ST_READOUT;
      cmd_o.al_bin = word_i.length_or_bin;
    end else if (!pass) begin
      cmd_o.kind = alh_pkg::ST_FILTERED;
    end else if (!in_range || (clip > len_ext)) begin
      cmd_o.kind = alh_pkg::ST_RANGE;
    end else begin
      cmd_o.kind = alh_pkg::ST_COUNTED;
    end
  end

endmodule

`default_nettype wire

// ----- design/alh_back.sv -----
// back end: histogram memories with read, update and bypass, plus result queue
`timescale 1ns / 1ps
`default_nettype none
`include "alignment_length_histogram_unit_macros.svh"

module alh_back #(
  parameter int BIN_COUNT = alh_pkg::BIN_COUNT_DEFAULT
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire alh_pkg::cmd_t   cmd_i,
  input  wire logic            cmd_valid_i,
  output logic                 cmd_pop_o,
  output logic                 ready_o,
  output alh_pkg::out_word_t   out_data_o,
  output logic                 out_empty_o,
  input  wire logic            out_pop_i
);

  localparam int IDX_W   = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
  localparam int COUNT_W = alh_pkg::COUNT_W;
  localparam int ODEPTH  = alh_pkg::OUT_DEPTH;
  localparam int OCNT_W  = $clog2(ODEPTH+1);

  logic [COUNT_W-1:0] rl_mem [BIN_COUNT];
  logic [COUNT_W-1:0] al_mem [BIN_COUNT];

  logic               clear_done_q;
  logic [IDX_W-1:0]   clr_cnt_q;

  logic               issue;
  logic [OCNT_W:0]    occupancy;
  logic [OCNT_W-1:0]  oq_cnt;

  logic               e_valid_q;
  alh_pkg::cmd_t      e_cmd_q;
  logic [COUNT_W-1:0] rl_rd_q, al_rd_q;
  logic [IDX_W-1:0]   e_rl_addr, e_al_addr;

  logic               lw_rl_valid_q, lw_al_valid_q;
  logic [IDX_W-1:0]   lw_rl_addr_q, lw_al_addr_q;
  logic [COUNT_W-1:0] lw_rl_data_q, lw_al_data_q;

  logic [COUNT_W-1:0] rl_cur, al_cur, rl_next, al_next;
  logic               count_we;
  logic               mem_we;
  logic [IDX_W-1:0]   rl_wa, al_wa;
  logic [COUNT_W-1:0] rl_wd, al_wd;
  alh_pkg::out_word_t e_result;

  // clearing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_done_q <= 1'b0;
      clr_cnt_q    <= '0;
    end else if (!clear_done_q) begin
      clr_cnt_q <= clr_cnt_q + IDX_W'(1);
      if (clr_cnt_q == IDX_W'(BIN_COUNT-1)) clear_done_q <= 1'b1;
    end
  end

  // issue only when the result queue has room for everything in flight
  assign occupancy = (OCNT_W+1)'(oq_cnt) + (OCNT_W+1)'(e_valid_q);
  assign issue     = cmd_valid_i && clear_done_q && (occupancy < (OCNT_W+1)'(ODEPTH));
  assign cmd_pop_o = issue;
  assign ready_o   = clear_done_q;

  // update stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q     <= 1'b0;
      lw_rl_valid_q <= 1'b0;
      lw_al_valid_q <= 1'b0;
    end else begin
      e_valid_q     <= issue;
      lw_rl_valid_q <= count_we;
      lw_al_valid_q <= count_we;
    end
  end

  // update stage payload and last write record
  always_ff @(posedge clk_i) begin
    e_cmd_q      <= cmd_i;
    lw_rl_addr_q <= e_rl_addr;
    lw_al_addr_q <= e_al_addr;
    lw_rl_data_q <= rl_next;
    lw_al_data_q <= al_next;
  end

  assign e_rl_addr = e_cmd_q.rl_bin[IDX_W-1:0];
  assign e_al_addr = e_cmd_q.al_bin[IDX_W-1:0];

  // bypass the write that the memory read could not see
  assign rl_cur = (lw_rl_valid_q && (lw_rl_addr_q == e_rl_addr)) ? lw_rl_data_q : rl_rd_q;
  assign al_cur = (lw_al_valid_q && (lw_al_addr_q == e_al_addr)) ? lw_al_data_q : al_rd_q;

  // saturating increments
  assign rl_next = (rl_cur == '1) ? rl_cur : rl_cur + COUNT_W'(1);
  assign al_next = (al_cur == '1) ? al_cur : al_cur + COUNT_W'(1);

  assign count_we = e_valid_q && (e_cmd_q.kind == alh_pkg::ST_COUNTED);

  // write port select: clearing pass or bin update
  always_comb begin
    mem_we = count_we;
    rl_wa  = e_rl_addr;
    al_wa  = e_al_addr;
    rl_wd  = rl_next;
    al_wd  = al_next;
    if (!clear_done_q) begin
      mem_we = 1'b1;
      rl_wa  = clr_cnt_q;
      al_wa  = clr_cnt_q;
      rl_wd  = '0;
      al_wd  = '0;
    end
  end

  // histogram memories, one write and one read port each
  always_ff @(posedge clk_i) begin
    if (mem_we) rl_mem[rl_wa] <= rl_wd;
    rl_rd_q <= rl_mem[cmd_i.rl_bin[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) al_mem[al_wa] <= al_wd;
    al_rd_q <= al_mem[cmd_i.al_bin[IDX_W-1:0]];
  end

  // result word
  always_comb begin
    e_result.status               = e_cmd_q.kind;
    e_result.read_length_count    = '0;
    e_result.aligned_length_count = '0;
    if ((e_cmd_q.kind == alh_pkg::ST_READOUT) && e_cmd_q.bin_ok) begin
      e_result.read_length_count    = rl_cur;
      e_result.aligned_length_count = al_cur;
    end
  end

  // result queue
  alh_fifo #(
    .WIDTH ($bits(alh_pkg::out_word_t)),
    .DEPTH (ODEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (e_valid_q),
    .data_i  (e_result),
    .pop_i   (out_pop_i && !out_empty_o),
    .data_o  (out_data_o),
    .count_o (oq_cnt)
  );

  assign out_empty_o = (oq_cnt == '0);

  `ALH_ASSERT(a_room_for_result, clk_i, rst_ni, e_valid_q |-> (oq_cnt != OCNT_W'(ODEPTH)), "result queue has no room")
  `ALH_ASSERT_NEVER(a_update_while_clearing, clk_i, rst_ni, count_we && !clear_done_q, "bin update during clearing pass")
  `ALH_ASSERT(a_counts_only_on_readout, clk_i, rst_ni, (e_valid_q && ((e_result.read_length_count != '0) || (e_result.aligned_length_count != '0))) |-> (e_cmd_q.kind == alh_pkg::ST_READOUT), "nonzero count on record result")

endmodule

`default_nettype wire

// ----- design/alignment_length_histogram_unit.sv -----
// top level of the alignment length histogram unit
`timescale 1ns / 1ps
`default_nettype none

// Filtered length histogram. Each input word either records one alignment or
// reads out one bin; every word yields exactly one result word, in order. A
// record in range passing the quality and flag filter bumps the read length
// bin and the read length minus soft clip bin, both saturating at all ones. The
// block takes one word per cycle while full is low: the front classifies it
// combinationally into a two entry queue, the back reads both histogram memories
// when it takes a word and updates and writes them in the next cycle, with a
// bypass of the previous write so back to back hits on one bin count correctly.
// A result waits in a four entry result queue. After reset a clearing pass
// zeroes both memories; full stays high for that time, while register writes
// are taken as usual. Registers sit at byte addresses 0 (min_quality),
// 4 (required_flags) and 8 (forbidden_flags).
module alignment_length_histogram_unit #(
  parameter int BIN_COUNT = alh_pkg::BIN_COUNT_DEFAULT
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // input word side
  input  wire logic               push,
  output logic                    full,
  input  wire alh_pkg::in_word_t  in_data_i,
  // result word side
  output logic                    empty,
  input  wire logic               pop,
  output alh_pkg::out_word_t      out_data_o,
  // register port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  localparam int MCNT_W = $clog2(alh_pkg::MID_DEPTH+1);

  alh_pkg::cfg_t   cfg_q;
  alh_pkg::cmd_t   front_cmd;
  alh_pkg::cmd_t   mid_cmd;
  logic [MCNT_W-1:0] mid_cnt;
  logic            mid_push;
  logic            mid_pop;
  logic            back_ready;
  logic            cfg_write;

  // register writes
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_quality     <= '0;
      cfg_q.required_flags  <= '0;
      cfg_q.forbidden_flags <= alh_pkg::FORBIDDEN_RESET;
    end else if (cfg_write) begin
      case (paddr[3:2])
        alh_pkg::REG_MIN_QUALITY:     cfg_q.min_quality     <= pwdata[alh_pkg::QUAL_W-1:0];
        alh_pkg::REG_REQUIRED_FLAGS:  cfg_q.required_flags  <= pwdata[alh_pkg::FLAG_W-1:0];
        alh_pkg::REG_FORBIDDEN_FLAGS: cfg_q.forbidden_flags <= pwdata[alh_pkg::FLAG_W-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (paddr[3:2])
      alh_pkg::REG_MIN_QUALITY:     prdata = 32'(cfg_q.min_quality);
      alh_pkg::REG_REQUIRED_FLAGS:  prdata = 32'(cfg_q.required_flags);
      alh_pkg::REG_FORBIDDEN_FLAGS: prdata = 32'(cfg_q.forbidden_flags);
      default:                      prdata = '0;
    endcase
  end

  // front end
  alh_front #(
    .BIN_COUNT (BIN_COUNT)
  ) u_front (
    .word_i (in_data_i),
    .cfg_i  (cfg_q),
    .cmd_o  (front_cmd)
  );

  // queue between front and back
  assign full     = (mid_cnt == MCNT_W'(alh_pkg::MID_DEPTH)) || !back_ready;
  assign mid_push = push && !full;

  alh_fifo #(
    .WIDTH ($bits(alh_pkg::cmd_t)),
    .DEPTH (alh_pkg::MID_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (front_cmd),
    .pop_i   (mid_pop),
    .data_o  (mid_cmd),
    .count_o (mid_cnt)
  );

  // back end
  alh_back #(
    .BIN_COUNT (BIN_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (mid_cmd),
    .cmd_valid_i (mid_cnt != '0),
    .cmd_pop_o   (mid_pop),
    .ready_o     (back_ready),
    .out_data_o  (out_data_o),
    .out_empty_o (empty),
    .out_pop_i   (pop)
  );

endmodule

`default_nettype wire
